@@ src/gm_pkg.sv @@
// Shared types and constants of the wildcard glob matcher.
// Used by gm_cell and wildcard_glob_matcher; depends on nothing.

package gm_pkg;

  localparam int MAX_PATTERN = 32;

  localparam logic [7:0] SYM_STAR = 8'd42;
  localparam logic [7:0] SYM_ANY  = 8'd63;

  localparam logic CMD_PATTERN = 1'b0;
  localparam logic CMD_TEXT    = 1'b1;

  localparam logic KIND_LOAD = 1'b0;
  localparam logic KIND_TEXT = 1'b1;

  typedef enum logic [1:0] {
    ROW_HOLD  = 2'd0,
    ROW_CLEAR = 2'd1,
    ROW_ADV   = 2'd2,
    ROW_ARM   = 2'd3
  } row_op_e;

  typedef struct packed {
    logic       wr;
    logic [7:0] symbol;
    row_op_e    op;
  } cell_ctrl_t;

endpackage

@@ src/gm_cell.sv @@
// One pattern position of the matcher: its pattern byte and its match bit.
// Takes the chain bits of its left neighbor and hands its own to the right.
// Depends on gm_pkg.

module gm_cell #(
  parameter int CntW = 6,
  parameter int Idx  = 1
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  gm_pkg::cell_ctrl_t ctrl_i,
  input  logic [CntW-1:0]    base_i,
  input  logic [CntW-1:0]    count_i,
  input  logic               adv_prev_i,
  input  logic               row_prev_i,
  input  logic               arm_prev_i,
  output logic               adv_o,
  output logic               arm_o,
  output logic               row_o
);

  logic [7:0] sym_q;
  logic [7:0] sym_eff;
  logic       wr_here;
  logic       active;
  logic       is_star;
  logic       hit;
  logic       row_q;
  logic       row_d;

  assign wr_here = ctrl_i.wr && (base_i == CntW'(Idx - 1));
  assign sym_eff = wr_here ? ctrl_i.symbol : sym_q;
  assign active  = count_i >= CntW'(Idx);
  assign is_star = sym_eff == gm_pkg::SYM_STAR;
  assign hit     = (sym_eff == gm_pkg::SYM_ANY) || (sym_eff == ctrl_i.symbol);

  assign adv_o = active & (is_star ? (adv_prev_i | row_q) : (hit & row_prev_i));
  assign arm_o = active & is_star & arm_prev_i;
  assign row_o = row_q;

  always_comb begin
    unique case (ctrl_i.op)
      gm_pkg::ROW_HOLD:  row_d = row_q;
      gm_pkg::ROW_CLEAR: row_d = 1'b0;
      gm_pkg::ROW_ADV:   row_d = adv_o;
      gm_pkg::ROW_ARM:   row_d = arm_o;
      default:           row_d = row_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (wr_here) begin
      sym_q <= ctrl_i.symbol;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_q <= 1'b0;
    end else begin
      row_q <= row_d;
    end
  end

endmodule

@@ src/wildcard_glob_matcher.sv @@
// Top level of the wildcard glob matcher: control, row of pattern cells, result register.
// Depends on gm_pkg and gm_cell.
//
//   channel  direction  handshake              payload
//   in       input      in_valid_i/in_ready_o   cmd_i, symbol_i, last_i
//   out      output     out_valid_o/out_ready_i kind_o, match_o, status_o, text_end_o
//
// The match row of all cells updates in the accepting cycle,
// with the star run rippling through the cells, and the verdict is registered.
// A new word is taken while a result waits, as long as that result leaves in the same cycle.
// A word that yields no result is simply absorbed.
// After reset the pattern is empty and the row holds only position zero.

module wildcard_glob_matcher #(
  parameter int MaxPattern = gm_pkg::MAX_PATTERN
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic       cmd_i,
  input  logic [7:0] symbol_i,
  input  logic       last_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic       kind_o,
  output logic       match_o,
  output logic       status_o,
  output logic       text_end_o
);

  localparam int CntW = $clog2(MaxPattern + 1);

  logic                 accept;
  logic                 is_text;
  logic [CntW-1:0]      count_q, count_d, base;
  logic                 open_q, open_d;
  logic                 ovf_q, ovf_d;
  logic                 row0_q, row0_d;
  logic                 room;
  gm_pkg::cell_ctrl_t   ctrl;
  logic [MaxPattern:0]  adv_vec, arm_vec, row_vec;
  logic                 res_valid, res_kind, res_match, res_status, res_end;
  logic                 out_valid_q, kind_q, match_q, status_q, end_q;

  assign in_ready_o = !out_valid_q || out_ready_i;
  assign accept     = in_valid_i && in_ready_o;
  assign is_text    = cmd_i == gm_pkg::CMD_TEXT;
  assign base       = open_q ? count_q : '0;
  assign room       = base < CntW'(MaxPattern);

  always_comb begin
    count_d       = count_q;
    open_d        = open_q;
    ovf_d         = ovf_q;
    row0_d        = row0_q;
    ctrl.wr       = 1'b0;
    ctrl.symbol   = symbol_i;
    ctrl.op       = gm_pkg::ROW_HOLD;
    if (accept) begin
      if (is_text) begin
        open_d  = 1'b0;
        ctrl.op = last_i ? gm_pkg::ROW_ARM : gm_pkg::ROW_ADV;
        row0_d  = last_i;
      end else begin
        ctrl.wr = room;
        count_d = room ? base + CntW'(1) : base;
        ovf_d   = (open_q & ovf_q) | !room;
        open_d  = !last_i;
        if (last_i) begin
          ctrl.op = gm_pkg::ROW_ARM;
          row0_d  = 1'b1;
        end else if (!open_q) begin
          ctrl.op = gm_pkg::ROW_CLEAR;
          row0_d  = 1'b1;
        end
      end
    end
  end

  assign adv_vec[0] = 1'b0;
  assign arm_vec[0] = 1'b1;
  assign row_vec[0] = row0_q;

  for (genvar k = 1; k <= MaxPattern; k++) begin : g_cell
    gm_cell #(
      .CntW(CntW),
      .Idx (k)
    ) u_cell (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .ctrl_i    (ctrl),
      .base_i    (base),
      .count_i   (count_d),
      .adv_prev_i(adv_vec[k-1]),
      .row_prev_i(row_vec[k-1]),
      .arm_prev_i(arm_vec[k-1]),
      .adv_o     (adv_vec[k]),
      .arm_o     (arm_vec[k]),
      .row_o     (row_vec[k])
    );
  end

  always_comb begin
    res_valid  = 1'b0;
    res_kind   = gm_pkg::KIND_TEXT;
    res_match  = adv_vec[count_q];
    res_status = ovf_q;
    res_end    = last_i;
    if (accept) begin
      if (is_text) begin
        res_valid = 1'b1;
      end else begin
        res_valid  = last_i;
        res_kind   = gm_pkg::KIND_LOAD;
        res_match  = arm_vec[count_d];
        res_status = ovf_d;
        res_end    = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      open_q      <= 1'b0;
      ovf_q       <= 1'b0;
      row0_q      <= 1'b1;
      out_valid_q <= 1'b0;
    end else begin
      count_q <= count_d;
      open_q  <= open_d;
      ovf_q   <= ovf_d;
      row0_q  <= row0_d;
      if (accept) begin
        out_valid_q <= res_valid;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept && res_valid) begin
      kind_q   <= res_kind;
      match_q  <= res_match;
      status_q <= res_status;
      end_q    <= res_end;
    end
  end

  assign out_valid_o = out_valid_q;
  assign kind_o      = kind_q;
  assign match_o     = match_q;
  assign status_o    = status_q;
  assign text_end_o  = end_q;

endmodule

@@ src/gm_checker.sv @@
// Port-level checks of the wildcard glob matcher, bound to its top level.
// Depends on wildcard_glob_matcher and gm_pkg.

module gm_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_valid_i,
  input logic       in_ready_o,
  input logic       cmd_i,
  input logic       out_valid_o,
  input logic       out_ready_i,
  input logic       kind_o,
  input logic       text_end_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o)
    else $error("result word dropped while stalled");

  a_ready_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |-> in_ready_o)
    else $error("input stalled with an empty output register");

  a_text_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && (cmd_i == gm_pkg::CMD_TEXT) |=>
      out_valid_o && (kind_o == gm_pkg::KIND_TEXT))
    else $error("text word gave no text verdict");

  a_load_no_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (kind_o == gm_pkg::KIND_LOAD) |-> !text_end_o)
    else $error("load verdict carries a text end flag");

endmodule

bind wildcard_glob_matcher gm_checker u_gm_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .in_valid_i (in_valid_i),
  .in_ready_o (in_ready_o),
  .cmd_i      (cmd_i),
  .out_valid_o(out_valid_o),
  .out_ready_i(out_ready_i),
  .kind_o     (kind_o),
  .text_end_o (text_end_o)
);

@@ dv/testbench.sv @@
// Self-checking testbench for the wildcard glob matcher: directed words, then random phases.
// A scoreboard class predicts each verdict from the accepted words and checks the results.
// Depends on gm_pkg and wildcard_glob_matcher.

module testbench;

  localparam int WATCHDOG_LIMIT = 10000;
  localparam int HOLD_CYCLES = 400;
  localparam logic [7:0] CH_A = 8'h61;
  localparam logic [7:0] CH_B = 8'h62;
  localparam logic [7:0] CH_Q = 8'h71;
  localparam logic [7:0] CH_Z = 8'h7A;

  typedef struct packed {
    logic kind;
    logic match;
    logic status;
    logic text_end;
  } verdict_t;

  class glob_checker;
    logic [7:0] pat_mem [gm_pkg::MAX_PATTERN];
    int unsigned pat_len;
    bit loading;
    bit ovf;
    logic [gm_pkg::MAX_PATTERN:0] row;
    verdict_t verdict_q[$];
    int unsigned errors;

    function new();
      pat_len = 0;
      loading = 1'b0;
      ovf = 1'b0;
      row = '0;
      row[0] = 1'b1;
      errors = 0;
    endfunction

    function void arm_row();
      row = '0;
      row[0] = 1'b1;
      for (int k = 1; k <= pat_len; k++) begin
        row[k] = row[k-1] && (pat_mem[k-1] == gm_pkg::SYM_STAR);
      end
    endfunction

    function void advance_row(logic [7:0] c);
      logic [gm_pkg::MAX_PATTERN:0] nxt;
      nxt = '0;
      for (int k = 1; k <= pat_len; k++) begin
        if (pat_mem[k-1] == gm_pkg::SYM_STAR) begin
          nxt[k] = nxt[k-1] | row[k];
        end else if (pat_mem[k-1] == gm_pkg::SYM_ANY || pat_mem[k-1] == c) begin
          nxt[k] = row[k-1];
        end
      end
      row = nxt;
    endfunction

    function void take_word(logic c, logic [7:0] s, logic l);
      verdict_t v;
      if (c == gm_pkg::CMD_PATTERN) begin
        if (!loading) begin
          pat_len = 0;
          ovf = 1'b0;
          loading = 1'b1;
          row = '0;
          row[0] = 1'b1;
        end
        if (pat_len < gm_pkg::MAX_PATTERN) begin
          pat_mem[pat_len] = s;
          pat_len++;
        end else begin
          ovf = 1'b1;
        end
        if (l) begin
          loading = 1'b0;
          arm_row();
          v.kind = gm_pkg::KIND_LOAD;
          v.match = row[pat_len];
          v.status = ovf;
          v.text_end = 1'b0;
          verdict_q.push_back(v);
        end
      end else begin
        loading = 1'b0;
        advance_row(s);
        v.kind = gm_pkg::KIND_TEXT;
        v.match = row[pat_len];
        v.status = ovf;
        v.text_end = l;
        verdict_q.push_back(v);
        if (l) begin
          arm_row();
        end
      end
    endfunction

    function void compare_bit(string name, logic want, logic got);
      if (got !== want) begin
        errors++;
        $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      end
    endfunction

    function void check_verdict(verdict_t got);
      verdict_t want;
      if (verdict_q.size() == 0) begin
        errors++;
        $display("%0t: unexpected result, expected none, actual %b", $time, got);
        return;
      end
      want = verdict_q.pop_front();
      compare_bit("kind", want.kind, got.kind);
      compare_bit("match", want.match, got.match);
      compare_bit("status", want.status, got.status);
      compare_bit("text_end", want.text_end, got.text_end);
    endfunction
  endclass

  logic clk_i;
  logic rst_ni = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic cmd = 1'b0;
  logic [7:0] symbol = 8'h00;
  logic last = 1'b0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic kind;
  logic match;
  logic status;
  logic text_end;

  glob_checker chk = new();
  int in_idle = 0;
  int out_stall = 0;
  int words_sent = 0;
  int hold_reqs = 0;
  int hold_seen = 0;
  int hold_left = 0;
  int quiet = 0;
  logic [7:0] cur_pat[$];

  wildcard_glob_matcher dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid),
    .in_ready_o (in_ready),
    .cmd_i      (cmd),
    .symbol_i   (symbol),
    .last_i     (last),
    .out_valid_o(out_valid),
    .out_ready_i(out_ready),
    .kind_o     (kind),
    .match_o    (match),
    .status_o   (status),
    .text_end_o (text_end)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid && out_ready) begin
        chk.check_verdict({kind, match, status, text_end});
      end
      if (in_valid && in_ready) begin
        chk.take_word(cmd, symbol, last);
      end
    end
  end

  always @(posedge clk_i) begin
    if (hold_reqs != hold_seen) begin
      hold_seen <= hold_reqs;
      hold_left <= HOLD_CYCLES;
      out_ready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= out_stall);
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet <= 0;
    end else if (quiet == WATCHDOG_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end else begin
      quiet <= quiet + 1;
    end
  end

  task automatic send_word(logic c, logic [7:0] s, logic l);
    while ($urandom_range(99) < in_idle) begin
      in_valid <= 1'b0;
      @(posedge clk_i);
    end
    in_valid <= 1'b1;
    cmd <= c;
    symbol <= s;
    last <= l;
    @(posedge clk_i);
    while (!in_ready) @(posedge clk_i);
    words_sent++;
  endtask

  task automatic wait_drain();
    in_valid <= 1'b0;
    @(posedge clk_i);
    while (chk.verdict_q.size() != 0) @(posedge clk_i);
  endtask

  function automatic logic [7:0] text_char();
    if ($urandom_range(9) == 0) begin
      return 8'($urandom_range(255));
    end
    return CH_A + 8'($urandom_range(2));
  endfunction

  function automatic logic [7:0] pattern_char();
    int r;
    r = $urandom_range(19);
    if (r < 5) begin
      return gm_pkg::SYM_STAR;
    end else if (r < 8) begin
      return gm_pkg::SYM_ANY;
    end else if (r < 18) begin
      return CH_A + 8'($urandom_range(2));
    end
    return 8'($urandom_range(255));
  endfunction

  task automatic send_pattern(int len, bit close);
    logic [7:0] c;
    cur_pat.delete();
    for (int i = 0; i < len; i++) begin
      c = pattern_char();
      cur_pat.push_back(c);
      send_word(gm_pkg::CMD_PATTERN, c, close && (i == len - 1));
    end
  endtask

  task automatic send_text();
    logic [7:0] txt[$];
    int reps;
    if ($urandom_range(1) == 0) begin
      foreach (cur_pat[i]) begin
        if (cur_pat[i] == gm_pkg::SYM_STAR) begin
          reps = $urandom_range(2);
          repeat (reps) txt.push_back(text_char());
        end else if (cur_pat[i] == gm_pkg::SYM_ANY) begin
          txt.push_back(text_char());
        end else begin
          txt.push_back(cur_pat[i]);
        end
      end
      if (txt.size() != 0 && $urandom_range(4) == 0) begin
        txt[$urandom_range(txt.size() - 1)] = text_char();
      end
    end else begin
      repeat ($urandom_range(8, 1)) txt.push_back(text_char());
    end
    if (txt.size() == 0) begin
      txt.push_back(text_char());
    end
    foreach (txt[i]) send_word(gm_pkg::CMD_TEXT, txt[i], i == txt.size() - 1);
  endtask

  task automatic random_round();
    int r;
    int n;
    r = $urandom_range(99);
    if (r < 75) begin
      n = ($urandom_range(9) == 0) ? $urandom_range(40, 25) : $urandom_range(8, 1);
      send_pattern(n, 1'b1);
      repeat ($urandom_range(4, 1)) send_text();
    end else if (r < 85) begin
      // The load is left open and the first text word closes it.
      send_pattern($urandom_range(5, 1), 1'b0);
      repeat ($urandom_range(2, 1)) send_text();
    end else if (r < 95) begin
      send_text();
    end else begin
      repeat ($urandom_range(6, 1)) begin
        send_word(1'($urandom_range(1)), 8'($urandom_range(255)), 1'($urandom_range(1)));
      end
    end
  endtask

  task automatic run_phase(int in_pct, int out_pct, int count, bit squeeze);
    int stop_at;
    in_idle = in_pct;
    out_stall = out_pct;
    stop_at = words_sent + count;
    if (squeeze) begin
      hold_reqs <= hold_reqs + 1;
    end
    while (words_sent < stop_at) random_round();
  endtask

  initial begin
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Text before any pattern can never match.
    send_word(gm_pkg::CMD_TEXT, CH_A, 1'b0);
    send_word(gm_pkg::CMD_TEXT, 8'hFF, 1'b1);
    send_word(gm_pkg::CMD_PATTERN, gm_pkg::SYM_STAR, 1'b1);
    send_word(gm_pkg::CMD_TEXT, 8'h00, 1'b1);
    send_word(gm_pkg::CMD_PATTERN, gm_pkg::SYM_ANY, 1'b0);
    send_word(gm_pkg::CMD_PATTERN, CH_A, 1'b0);
    send_word(gm_pkg::CMD_PATTERN, gm_pkg::SYM_STAR, 1'b1);
    send_word(gm_pkg::CMD_TEXT, CH_Z, 1'b0);
    send_word(gm_pkg::CMD_TEXT, CH_A, 1'b0);
    send_word(gm_pkg::CMD_TEXT, CH_Q, 1'b1);
    send_word(gm_pkg::CMD_TEXT, CH_A, 1'b1);
    send_word(gm_pkg::CMD_PATTERN, CH_A, 1'b0);
    send_word(gm_pkg::CMD_TEXT, CH_A, 1'b1);
    send_word(gm_pkg::CMD_PATTERN, CH_B, 1'b0);
    send_word(gm_pkg::CMD_PATTERN, gm_pkg::SYM_ANY, 1'b1);
    send_word(gm_pkg::CMD_TEXT, CH_B, 1'b1);
    send_word(gm_pkg::CMD_PATTERN, gm_pkg::SYM_STAR, 1'b0);
    send_word(gm_pkg::CMD_PATTERN, CH_B, 1'b1);
    send_word(gm_pkg::CMD_TEXT, 8'hFF, 1'b0);
    send_word(gm_pkg::CMD_TEXT, CH_B, 1'b1);
    wait_drain();

    run_phase(0, 0, 180, 1'b1);
    wait_drain();
    run_phase(79, 0, 150, 1'b0);
    run_phase(0, 79, 150, 1'b0);
    run_phase(35, 35, 150, 1'b0);
    run_phase(0, 0, 170, 1'b0);

    wait_drain();
    repeat (8) @(posedge clk_i);
    if (chk.errors == 0 && chk.verdict_q.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
